/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property under the given clock and active-low reset.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property that must also hold during reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* hdl/ifrt_pkg.sv */
// Package with types and constants of the fragment reassembly tracker.
`default_nettype none
package ifrt_pkg;
    localparam int NUM_CONTEXTS = 4;
    localparam int FRAGS_PER_CONTEXT = 8;
    localparam int CTX_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int SLOT_W = (FRAGS_PER_CONTEXT > 1) ? $clog2(FRAGS_PER_CONTEXT) : 1;
    localparam int CNT_W = $clog2(FRAGS_PER_CONTEXT + 1);
    localparam logic [31:0] TIMEOUT_RESET = 32'd60;
    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_NO_CTX = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    typedef struct packed {
        logic [15:0] offset;
        logic [15:0] size;
        logic        last;
    } slot_t;
endpackage
`default_nettype wire

/* hdl/ipv4_fragment_reassembly_tracker_unit.sv */
// Top level of the IPv4 fragment reassembly tracker.
// Usage: one fragment descriptor is taken per input word on in_valid/in_ready.
// Each word yields one result word (stored, dropped) or, when its context
// completes, one result word per stored fragment in offset order, with
// end_of_run set on the final one. The unit works on one fragment at a time:
// a sequencer steps one context per cycle for expiry and then for matching,
// then one slot per cycle for the ordered insert and one slot per cycle for
// the completeness walk, using an age subtractor and a running offset adder.
// Configuration writes on cfg_valid/cfg_ready load the timeout from
// reassembly_timeout; they are taken at any time but are meant for idle.
// Reset clears all contexts and loads a timeout of 60. When the receiver
// stalls, the current result word holds in the output register and the
// sequencer waits; no input is taken until the last result word is taken.
`default_nettype none
module ipv4_fragment_reassembly_tracker_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] reassembly_timeout,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] source_addr,
    input  wire logic [31:0] dest_addr,
    input  wire logic [7:0]  protocol_num,
    input  wire logic [15:0] ident,
    input  wire logic [15:0] frag_offset,
    input  wire logic [15:0] frag_size,
    input  wire logic        frag_is_last,
    input  wire logic [31:0] now_time,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [1:0]       context_index,
    output logic [15:0]      out_offset,
    output logic [15:0]      out_size,
    output logic             out_is_last,
    output logic [19:0]      total_length,
    output logic             end_of_run
);
    import ifrt_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXPIRE = 4'd1;
    localparam logic [3:0] S_MATCH  = 4'd2;
    localparam logic [3:0] S_OPEN   = 4'd3;
    localparam logic [3:0] S_FIND   = 4'd4;
    localparam logic [3:0] S_SHIFT  = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam int CI_W = CTX_W + 1;
    localparam int SI_W = SLOT_W + 1;
    localparam int SUM_W = 33;

    // Context table and fragment slots
    logic [NUM_CONTEXTS-1:0] ctx_valid_reg, ctx_valid_next;
    logic [CNT_W-1:0] ctx_count_reg [NUM_CONTEXTS];
    logic [31:0] ctx_source_mem [NUM_CONTEXTS];
    logic [31:0] ctx_dest_mem   [NUM_CONTEXTS];
    logic [7:0]  ctx_protocol_mem [NUM_CONTEXTS];
    logic [15:0] ctx_ident_mem  [NUM_CONTEXTS];
    logic [31:0] ctx_start_mem  [NUM_CONTEXTS];
    slot_t slot_mem [NUM_CONTEXTS][FRAGS_PER_CONTEXT];

    logic [31:0] timeout_reg;
    logic [3:0]  state_reg, state_next;
    logic [CI_W-1:0] cidx_reg, cidx_next;
    logic [SI_W-1:0] sidx_reg, sidx_next;
    logic [SI_W-1:0] pos_reg, pos_next;
    logic [CTX_W-1:0] hit_reg, hit_next;
    logic hit_found_reg, hit_found_next;
    logic [CTX_W-1:0] fresh_reg, fresh_next;
    logic fresh_found_reg, fresh_found_next;
    logic [SUM_W-1:0] expect_reg, expect_next;
    logic done_reg, done_next;
    logic ok_reg, ok_next;

    // Held input word
    logic [31:0] src_reg, dst_reg, now_reg;
    logic [7:0]  proto_reg;
    logic [15:0] id_reg;
    slot_t frag_reg;

    // Output register
    logic [1:0]  status_reg;
    logic [CTX_W-1:0] oci_reg;
    slot_t oslot_reg;
    logic [19:0] total_reg;
    logic        eor_reg;
    logic        ovalid_reg;

    logic [CTX_W-1:0] cur_c;
    logic [SLOT_W-1:0] cur_s, prev_s;
    logic [CNT_W-1:0] hit_cnt;
    slot_t cur_slot;
    logic [31:0] age;
    logic tuple_eq;
    logic [SUM_W-1:0] sum;

    assign cur_c = cidx_reg[CTX_W-1:0];
    assign cur_s = sidx_reg[SLOT_W-1:0];
    assign prev_s = cur_s - SLOT_W'(1);
    assign hit_cnt = ctx_count_reg[hit_reg];
    assign cur_slot = slot_mem[hit_reg][cur_s];
    // Age subtract and running offset add
    assign age = now_reg - ctx_start_mem[cur_c];
    assign sum = expect_reg + SUM_W'(cur_slot.size);
    assign tuple_eq = (ctx_source_mem[cur_c] == src_reg) && (ctx_dest_mem[cur_c] == dst_reg)
                   && (ctx_protocol_mem[cur_c] == proto_reg) && (ctx_ident_mem[cur_c] == id_reg);

    assign in_ready = (state_reg == S_IDLE) && !ovalid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = ovalid_reg;
    assign status = status_reg;
    assign context_index = 2'(oci_reg);
    assign out_offset = oslot_reg.offset;
    assign out_size = oslot_reg.size;
    assign out_is_last = oslot_reg.last;
    assign total_length = total_reg;
    assign end_of_run = eor_reg;

    logic out_load;
    logic [1:0] out_status;
    logic out_eor;
    logic wr_open;
    logic wr_shift;
    logic wr_insert;
    logic cnt_inc;
    logic cnt_clr;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cidx_next = cidx_reg;
        sidx_next = sidx_reg;
        pos_next = pos_reg;
        hit_next = hit_reg;
        hit_found_next = hit_found_reg;
        fresh_next = fresh_reg;
        fresh_found_next = fresh_found_reg;
        expect_next = expect_reg;
        done_next = done_reg;
        ok_next = ok_reg;
        ctx_valid_next = ctx_valid_reg;
        out_load = 1'b0;
        out_status = ST_STORED;
        out_eor = 1'b1;
        wr_open = 1'b0;
        wr_shift = 1'b0;
        wr_insert = 1'b0;
        cnt_inc = 1'b0;
        cnt_clr = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_EXPIRE;
                    cidx_next = '0;
                end
            end
            S_EXPIRE:
            begin
                // Check one context per cycle and drop it if expired
                if (ctx_valid_reg[cur_c] && (age > timeout_reg))
                    ctx_valid_next[cur_c] = 1'b0;
                if (cidx_reg == CI_W'(NUM_CONTEXTS - 1))
                begin
                    state_next = S_MATCH;
                    cidx_next = '0;
                    hit_found_next = 1'b0;
                    fresh_found_next = 1'b0;
                end
                else
                    cidx_next = cidx_reg + 1'b1;
            end
            S_MATCH:
            begin
                if (ctx_valid_reg[cur_c] && !hit_found_reg && tuple_eq)
                begin
                    hit_found_next = 1'b1;
                    hit_next = cur_c;
                end
                if (!ctx_valid_reg[cur_c] && !fresh_found_reg)
                begin
                    fresh_found_next = 1'b1;
                    fresh_next = cur_c;
                end
                if (cidx_reg == CI_W'(NUM_CONTEXTS - 1))
                    state_next = S_OPEN;
                else
                    cidx_next = cidx_reg + 1'b1;
            end
            S_OPEN:
            begin
                if (!hit_found_reg && !fresh_found_reg)
                begin
                    out_load = 1'b1;
                    out_status = ST_NO_CTX;
                    hit_next = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    if (!hit_found_reg)
                    begin
                        hit_next = fresh_reg;
                        wr_open = 1'b1;
                        ctx_valid_next[fresh_reg] = 1'b1;
                    end
                    sidx_next = '0;
                    state_next = S_FIND;
                end
            end
            S_FIND:
            begin
                // Report a full context, else find first stored offset greater than the new one
                if (hit_cnt >= CNT_W'(FRAGS_PER_CONTEXT))
                begin
                    out_load = 1'b1;
                    out_status = ST_FULL;
                    state_next = S_OUT;
                end
                else if ((SI_W'(hit_cnt) == sidx_reg) || (cur_slot.offset > frag_reg.offset))
                begin
                    pos_next = sidx_reg;
                    sidx_next = SI_W'(hit_cnt);
                    state_next = S_SHIFT;
                end
                else
                    sidx_next = sidx_reg + 1'b1;
            end
            S_SHIFT:
            begin
                // Move one slot up per cycle, then drop in the new fragment
                if (sidx_reg == pos_reg)
                begin
                    wr_insert = 1'b1;
                    cnt_inc = 1'b1;
                    sidx_next = '0;
                    expect_next = '0;
                    done_next = 1'b0;
                    ok_next = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    wr_shift = 1'b1;
                    sidx_next = sidx_reg - 1'b1;
                end
            end
            S_WALK:
            begin
                if (sidx_reg == SI_W'(hit_cnt))
                begin
                    if (ok_reg && done_reg)
                    begin
                        sidx_next = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        out_load = 1'b1;
                        out_status = ST_STORED;
                        state_next = S_OUT;
                    end
                end
                else if (done_reg || (SUM_W'(cur_slot.offset) > expect_reg))
                begin
                    ok_next = 1'b0;
                    sidx_next = SI_W'(hit_cnt);
                end
                else
                begin
                    if (cur_slot.last)
                        done_next = 1'b1;
                    expect_next = sum;
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                // Present one ordered fragment per result word
                if (!ovalid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    out_status = ST_COMPLETE;
                    out_eor = (sidx_reg + 1'b1) == SI_W'(hit_cnt);
                    if (out_eor)
                    begin
                        cnt_clr = 1'b1;
                        ctx_valid_next[hit_reg] = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                        sidx_next = sidx_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctx_valid_reg <= '0;
            timeout_reg <= TIMEOUT_RESET;
            ovalid_reg <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++)
                ctx_count_reg[c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_valid_reg <= ctx_valid_next;
            if (cfg_valid)
                timeout_reg <= reassembly_timeout;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++)
            begin
                if (state_reg == S_EXPIRE && cur_c == CTX_W'(c)
                    && ctx_valid_reg[c] && (age > timeout_reg))
                    ctx_count_reg[c] <= '0;
            end
            if (wr_open || cnt_clr)
                ctx_count_reg[hit_next] <= '0;
            if (cnt_inc)
                ctx_count_reg[hit_reg] <= hit_cnt + 1'b1;
        end
    end

    // Datapath registers and stores
    always_ff @(posedge clk)
    begin
        cidx_reg <= cidx_next;
        sidx_reg <= sidx_next;
        pos_reg <= pos_next;
        hit_reg <= hit_next;
        hit_found_reg <= hit_found_next;
        fresh_reg <= fresh_next;
        fresh_found_reg <= fresh_found_next;
        expect_reg <= expect_next;
        done_reg <= done_next;
        ok_reg <= ok_next;
        if (in_valid && in_ready)
        begin
            src_reg <= source_addr;
            dst_reg <= dest_addr;
            proto_reg <= protocol_num;
            id_reg <= ident;
            now_reg <= now_time;
            frag_reg <= '{offset: frag_offset, size: frag_size, last: frag_is_last};
        end
        if (wr_open)
        begin
            ctx_source_mem[fresh_reg] <= src_reg;
            ctx_dest_mem[fresh_reg] <= dst_reg;
            ctx_protocol_mem[fresh_reg] <= proto_reg;
            ctx_ident_mem[fresh_reg] <= id_reg;
            ctx_start_mem[fresh_reg] <= now_reg;
        end
        if (wr_shift)
            slot_mem[hit_reg][cur_s] <= slot_mem[hit_reg][prev_s];
        if (wr_insert)
            slot_mem[hit_reg][cur_s] <= frag_reg;
        if (out_load)
        begin
            status_reg <= out_status;
            oci_reg <= hit_next;
            eor_reg <= out_eor;
            if (out_status == ST_COMPLETE)
            begin
                oslot_reg <= cur_slot;
                total_reg <= (expect_reg > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : expect_reg[19:0];
            end
            else
            begin
                oslot_reg <= '0;
                total_reg <= '0;
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/ifrt_checker.sv */
// Port-level checker for the fragment reassembly tracker, with its bind.
`default_nettype none
`include "assert_macros.svh"
module ifrt_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [15:0] out_offset,
    input wire logic [19:0] total_length,
    input wire logic        end_of_run
);
    import ifrt_pkg::*;

    `CHK_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !out_valid, "output word valid in reset")
    `CHK_ASSERT(a_no_accept_busy, clk, rst_n, out_valid |-> !in_ready, "input taken with result pending")
    `CHK_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status), "stalled result changed")
    `CHK_ASSERT(a_plain_eor, clk, rst_n, out_valid && status != ST_COMPLETE |-> end_of_run && total_length == 20'd0 && out_offset == 16'd0, "plain result malformed")
endmodule
bind ipv4_fragment_reassembly_tracker_unit ifrt_checker u_ifrt_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .out_offset(out_offset), .total_length(total_length), .end_of_run(end_of_run)
);
`default_nettype wire

/* sim/ipv4_fragment_reassembly_tracker_unit_tb.sv */
// Testbench of the IPv4 fragment reassembly tracker: directed table, then random fragment sets.
`default_nettype none
module ipv4_fragment_reassembly_tracker_unit_tb;
    import ifrt_pkg::*;

    typedef struct {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] id;
        logic [15:0] off;
        logic [15:0] size;
        logic        last;
        logic [31:0] now;
    } frag_t;

    typedef struct {
        logic [1:0]  st;
        logic [1:0]  ctx;
        logic [15:0] off;
        logic [15:0] size;
        logic        last;
        logic [19:0] total;
        logic        eor;
    } result_t;

    // Directed row: fragment, plus a typed-in last result where obvious.
    typedef struct {
        frag_t   frag;
        logic    has_exp;
        result_t exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [31:0] reassembly_timeout = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [31:0] source_addr = '0;
    logic [31:0] dest_addr = '0;
    logic [7:0] protocol_num = '0;
    logic [15:0] ident = '0;
    logic [15:0] frag_offset = '0;
    logic [15:0] frag_size = '0;
    logic frag_is_last = 1'b0;
    logic [31:0] now_time = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [1:0] context_index;
    logic [15:0] out_offset;
    logic [15:0] out_size;
    logic out_is_last;
    logic [19:0] total_length;
    logic end_of_run;

    ipv4_fragment_reassembly_tracker_unit dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .reassembly_timeout(reassembly_timeout),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .source_addr(source_addr),
        .dest_addr(dest_addr),
        .protocol_num(protocol_num),
        .ident(ident),
        .frag_offset(frag_offset),
        .frag_size(frag_size),
        .frag_is_last(frag_is_last),
        .now_time(now_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .context_index(context_index),
        .out_offset(out_offset),
        .out_size(out_size),
        .out_is_last(out_is_last),
        .total_length(total_length),
        .end_of_run(end_of_run)
    );

    always #5 clk = ~clk;

    // Shadow of the tracker state
    logic [31:0] sh_timeout;
    logic        sh_valid [NUM_CONTEXTS];
    logic [31:0] sh_src [NUM_CONTEXTS];
    logic [31:0] sh_dst [NUM_CONTEXTS];
    logic [7:0]  sh_proto [NUM_CONTEXTS];
    logic [15:0] sh_id [NUM_CONTEXTS];
    logic [31:0] sh_start [NUM_CONTEXTS];
    int          sh_count [NUM_CONTEXTS];
    slot_t       sh_slot [NUM_CONTEXTS][FRAGS_PER_CONTEXT];

    result_t expected_words[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit no_idle = 1'b0;
    int long_stall = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic clear_tracker();
        sh_timeout = TIMEOUT_RESET;
        for (int c = 0; c < NUM_CONTEXTS; c++)
        begin
            sh_valid[c] = 1'b0;
            sh_count[c] = 0;
        end
    endtask

    // Expire, match or open, insert in order, then walk for completeness.
    task automatic track_fragment(input frag_t f);
        int hit;
        int fresh;
        int n;
        int pos;
        logic [31:0] expect_off;
        bit done;
        bit ok;
        result_t r;
        hit = -1;
        fresh = -1;
        for (int c = 0; c < NUM_CONTEXTS; c++)
            if (sh_valid[c] && (f.now - sh_start[c]) > sh_timeout)
            begin
                sh_valid[c] = 1'b0;
                sh_count[c] = 0;
            end
        for (int c = 0; c < NUM_CONTEXTS; c++)
        begin
            if (sh_valid[c] && hit < 0 && sh_src[c] == f.src && sh_dst[c] == f.dst &&
                sh_proto[c] == f.proto && sh_id[c] == f.id)
                hit = c;
            if (!sh_valid[c] && fresh < 0)
                fresh = c;
        end
        r = '{ST_STORED, 2'd0, 16'd0, 16'd0, 1'b0, 20'd0, 1'b1};
        if (hit < 0)
        begin
            if (fresh < 0)
            begin
                r.st = ST_NO_CTX;
                expected_words.insert(expected_words.size(), r);
                return;
            end
            hit = fresh;
            sh_valid[hit] = 1'b1;
            sh_src[hit] = f.src;
            sh_dst[hit] = f.dst;
            sh_proto[hit] = f.proto;
            sh_id[hit] = f.id;
            sh_start[hit] = f.now;
            sh_count[hit] = 0;
        end
        r.ctx = hit[1:0];
        n = sh_count[hit];
        if (n >= FRAGS_PER_CONTEXT)
        begin
            r.st = ST_FULL;
            expected_words.insert(expected_words.size(), r);
            return;
        end
        pos = n;
        for (int i = n - 1; i >= 0; i--)
            if (sh_slot[hit][i].offset > f.off)
                pos = i;
        for (int i = n; i > pos; i--)
            sh_slot[hit][i] = sh_slot[hit][i - 1];
        sh_slot[hit][pos] = '{f.off, f.size, f.last};
        n++;
        sh_count[hit] = n;
        expect_off = 0;
        done = 1'b0;
        ok = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (ok && (done || sh_slot[hit][i].offset > expect_off))
                ok = 1'b0;
            if (ok)
            begin
                if (sh_slot[hit][i].last)
                    done = 1'b1;
                expect_off += sh_slot[hit][i].size;
            end
        end
        if (!ok || !done)
        begin
            expected_words.insert(expected_words.size(), r);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            r.st = ST_COMPLETE;
            r.off = sh_slot[hit][i].offset;
            r.size = sh_slot[hit][i].size;
            r.last = sh_slot[hit][i].last;
            r.total = (expect_off > TOTAL_MAX) ? TOTAL_MAX : expect_off[19:0];
            r.eor = (i == n - 1);
            expected_words.insert(expected_words.size(), r);
        end
        sh_valid[hit] = 1'b0;
        sh_count[hit] = 0;
    endtask

    task automatic random_gap();
        if (!no_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 14)) @(negedge clk);
    endtask

    task automatic send_fragment(input frag_t f);
        random_gap();
        source_addr <= f.src;
        dest_addr <= f.dst;
        protocol_num <= f.proto;
        ident <= f.id;
        frag_offset <= f.off;
        frag_size <= f.size;
        frag_is_last <= f.last;
        now_time <= f.now;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        track_fragment(f);
        @(negedge clk);
        in_valid <= 1'b0;
        // Let the drop of valid settle before the next word is offered
        @(negedge clk);
    endtask

    task automatic drain();
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        reassembly_timeout <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        sh_timeout = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output side: random stalls, one forced long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                for (long_stall = 0; long_stall < 300; long_stall++)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Compare each taken result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_words.pop_front();
                if (status !== e.st) report("status", status, e.st);
                if (context_index !== e.ctx) report("context_index", context_index, e.ctx);
                if (out_offset !== e.off) report("out_offset", out_offset, e.off);
                if (out_size !== e.size) report("out_size", out_size, e.size);
                if (out_is_last !== e.last) report("out_is_last", out_is_last, e.last);
                if (total_length !== e.total) report("total_length", total_length, e.total);
                if (end_of_run !== e.eor) report("end_of_run", end_of_run, e.eor);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("ipv4_fragment_reassembly_tracker_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic frag_t make_frag(input logic [31:0] s, input logic [15:0] id,
                                        input logic [15:0] off, input logic [15:0] size,
                                        input logic last, input logic [31:0] now);
        frag_t f;
        f = '{s, 32'hC0A8_0001, 8'd17, id, off, size, last, now};
        return f;
    endfunction

    row_t rows[$];
    frag_t set_frags[$];
    logic [31:0] clock_now;

    initial
    begin
        row_t w;
        result_t got_first;
        int sent;
        int nf;
        frag_t tmp;
        logic [15:0] run_off;
        logic [31:0] src_i;
        clear_tracker();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        w.has_exp = 1'b1;
        w.frag = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 32'd0};
        w.exp = '{ST_COMPLETE, 2'd0, 16'd0, 16'hFFFF, 1'b1, 20'h0FFFF, 1'b1};
        rows.insert(rows.size(), w);
        w.frag = '{32'd0, 32'd0, 8'd0, 16'd0, 16'hFFFF, 16'd0, 1'b0, 32'd1};
        w.exp = '{ST_STORED, 2'd0, 16'd0, 16'd0, 1'b0, 20'd0, 1'b1};
        rows.insert(rows.size(), w);
        w.has_exp = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            w.frag = make_frag(32'h1000 + k, 16'd5, 16'd100, 16'd8, 1'b0, 32'd2);
            rows.insert(rows.size(), w);
        end
        w.has_exp = 1'b1;
        w.frag = make_frag(32'h2000, 16'd5, 16'd0, 16'd8, 1'b0, 32'd3);
        w.exp = '{ST_NO_CTX, 2'd0, 16'd0, 16'd0, 1'b0, 20'd0, 1'b1};
        rows.insert(rows.size(), w);
        w.has_exp = 1'b0;
        for (int k = 0; k < 7; k++)
        begin
            w.frag = make_frag(32'h1000, 16'd5, 16'd200 + k, 16'd1, 1'b0, 32'd4);
            rows.insert(rows.size(), w);
        end
        w.has_exp = 1'b1;
        w.frag = make_frag(32'h1000, 16'd5, 16'd300, 16'd1, 1'b0, 32'd5);
        w.exp = '{ST_FULL, 2'd1, 16'd0, 16'd0, 1'b0, 20'd0, 1'b1};
        rows.insert(rows.size(), w);
        // Expire everything, then fill a context with equal offsets
        w.has_exp = 1'b0;
        for (int k = 0; k < 16; k++)
        begin
            w.frag = make_frag(32'h3000, 16'd9, 16'd0, 16'hFFFF, k == 15, 32'd1000);
            rows.insert(rows.size(), w);
            if (k == 7)
                break;
        end
        w.frag = make_frag(32'h3000, 16'd9, 16'd0, 16'hFFFF, 1'b0, 32'd1001);
        rows.insert(rows.size(), w);

        foreach (rows[i])
        begin
            send_fragment(rows[i].frag);
            if (rows[i].has_exp)
            begin
                got_first = expected_words[expected_words.size() - 1];
                if (got_first != rows[i].exp)
                begin
                    $display("table row %0d disagrees with tracker", i);
                    errors++;
                end
            end
        end
        drain();

        // Random part through several timeout settings
        clock_now = 32'hFFFF_FF00;
        sent = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_timeout(32'd0);
                1: write_timeout(32'hFFFF_FFFF);
                2: write_timeout($urandom_range(5, 40));
                default: write_timeout(32'd60);
            endcase
            if (phase == 2)
                hold_off = 1'b1;
            if (phase == 3)
                no_idle = 1'b1;
            for (int s = 0; s < 12; s++)
            begin
                nf = $urandom_range(1, 6);
                run_off = 0;
                set_frags.delete();
                src_i = $urandom_range(0, 3) == 0 ? $urandom() : {30'd0, 2'($urandom_range(0, 3))};
                for (int k = 0; k < nf; k++)
                begin
                    tmp = '{src_i, 32'h0A00_0001, 8'd6, 16'($urandom_range(0, 2)), run_off,
                            16'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(1, 64)),
                            k == nf - 1, 32'd0};
                    run_off += tmp.size;
                    set_frags.insert(set_frags.size(), tmp);
                end
                if ($urandom_range(0, 4) == 0)
                    set_frags.insert(set_frags.size(), '{$urandom(), $urandom(), 8'($urandom()),
                        16'($urandom()), 16'($urandom()), 16'($urandom()),
                        1'($urandom()), 32'd0});
                set_frags.shuffle();
                if ($urandom_range(0, 4) == 0)
                    void'(set_frags.pop_back());
                foreach (set_frags[k])
                begin
                    clock_now += $urandom_range(0, 3) == 0 ? $urandom_range(0, 80) : 1;
                    set_frags[k].now = clock_now;
                    send_fragment(set_frags[k]);
                    sent++;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("ipv4_fragment_reassembly_tracker_unit_tb: PASS");
        else
            $display("ipv4_fragment_reassembly_tracker_unit_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
